/* sv/spi_eeprom_page_sequencer_assert.svh */
// Assertion macros used by the checker of the page sequencer.
`ifndef SPI_EEPROM_PAGE_SEQUENCER_ASSERT_SVH
`define SPI_EEPROM_PAGE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, silent during reset.
`define SPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, silent during reset.
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// Shared codes, register defaults and types of the SPI EEPROM page sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int ADDR_WIDTH_DEF  = 24;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int MAX_RES         = 12;
  localparam int IDX_W           = 4;

  // input operations
  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_WRITE   = 3'd1;
  localparam logic [2:0] OP_WDATA   = 3'd2;
  localparam logic [2:0] OP_RXBYTE  = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;
  localparam logic [2:0] OP_PROTECT = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_SELECT  = 3'd0;
  localparam logic [2:0] KIND_SEND    = 3'd1;
  localparam logic [2:0] KIND_CLKIN   = 3'd2;
  localparam logic [2:0] KIND_RELEASE = 3'd3;
  localparam logic [2:0] KIND_RDBYTE  = 3'd4;
  localparam logic [2:0] KIND_DONE    = 3'd5;
  localparam logic [2:0] KIND_TIMEOUT = 3'd6;
  localparam logic [2:0] KIND_REJECT  = 3'd7;

  // device commands
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_WRSR  = 8'h01;

  // status register bit positions
  localparam int SR_WPEN = 7;
  localparam int SR_BP0  = 2;
  localparam int SR_BP1  = 3;

  // tail of a result sequence
  localparam logic [2:0] TL_NONE  = 3'd0;
  localparam logic [2:0] TL_ONE   = 3'd1;
  localparam logic [2:0] TL_POLL  = 3'd2;
  localparam logic [2:0] TL_CHUNK = 3'd3;
  localparam logic [2:0] TL_PROT  = 3'd4;

  // register map
  localparam logic [1:0] REG_ADDR_BYTES = 2'd0;
  localparam logic [1:0] REG_PAGE_LOG2  = 2'd1;
  localparam logic [1:0] REG_POLL       = 2'd2;
  localparam logic [1:0] REG_TIMEOUT    = 2'd3;

  localparam logic [1:0]  RST_ADDR_BYTES = 2'd2;
  localparam logic [3:0]  RST_PAGE_LOG2  = 4'd6;
  localparam logic        RST_POLL       = 1'b1;
  localparam logic [15:0] RST_TIMEOUT    = 16'd5000;

  typedef struct packed {
    logic [1:0]  addr_bytes;
    logic [3:0]  page_log2;
    logic        poll;
    logic [15:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
  } beat_t;

  // one accepted item's worth of results, in compact form
  typedef struct packed {
    logic        head_en;
    beat_t       head;
    logic        rel_en;
    logic [2:0]  tail;
    logic [2:0]  one_kind;
    logic        is_write;
    logic [1:0]  addr_bytes;
    logic [23:0] addr;
    logic [7:0]  status;
  } plan_t;

endpackage

/* sv/sps_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_if
// Valid/ready channels for the request items and the result beats.
// ----------------------------------------------------------------------------
interface sps_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [23:0] address;
  logic [23:0] length;
  logic [7:0]  data;
  logic        wp_enable;
  logic        block_protect0;
  logic        block_protect1;

  modport source (output valid, op, address, length, data, wp_enable,
                  block_protect0, block_protect1, input ready);
  modport sink (input valid, op, address, length, data, wp_enable,
                block_protect0, block_protect1, output ready);
endinterface

interface sps_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, kind, value, last, input ready);
  modport sink (input valid, kind, value, last, output ready);
endinterface

/* sv/sps_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_front
// Accept items, keep request state and emit one result plan per item other than a tick.
// ----------------------------------------------------------------------------
module sps_front #(
  parameter int ADDR_WIDTH = sps_pkg::ADDR_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  sps_in_if.sink          in_ch,
  input  sps_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            q_push,
  output sps_pkg::plan_t  q_plan
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RDATA = 2'd1;
  localparam logic [1:0] PH_WDATA = 2'd2;
  localparam logic [1:0] PH_POLL  = 2'd3;

  logic [1:0]            phase_r, phase_nxt;
  logic [ADDR_WIDTH-1:0] addr_r, addr_nxt;
  logic [23:0]           left_r, left_nxt;
  logic [8:0]            chunk_r, chunk_nxt;
  logic [15:0]           elapsed_r, elapsed_nxt;
  logic                  wr_r, wr_nxt;

  logic                  accept, is_req;
  logic [ADDR_WIDTH-1:0] addr_inc, st_addr;
  logic [23:0]           left_dec, st_left;
  logic [8:0]            chunk_dec, st_len;
  logic                  st_wr;
  logic [2:0]            nd_tail, nd_kind;
  logic [1:0]            nd_phase;
  logic [23:0]           nd_left;
  logic [8:0]            nd_chunk;

  function automatic logic [8:0] chunk_len(input logic [ADDR_WIDTH-1:0] a,
                                           input logic [23:0] bl,
                                           input logic [3:0] lg);
    logic [3:0] l;
    logic [8:0] page, off, room;
    l    = (lg > 4'd8) ? 4'd8 : lg;
    page = 9'd1 << l;
    off  = {1'b0, a[7:0]} & (page - 9'd1);
    room = page - off;
    return (bl < {15'd0, room}) ? bl[8:0] : room;
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign is_req      = (in_ch.op == sps_pkg::OP_READ) || (in_ch.op == sps_pkg::OP_WRITE);

  assign addr_inc  = addr_r + ADDR_WIDTH'(1);
  assign left_dec  = (left_r != 24'd0) ? left_r - 24'd1 : left_r;
  assign chunk_dec = (chunk_r != 9'd0) ? chunk_r - 9'd1 : chunk_r;

  // where the next chunk would start
  always_comb begin
    if (is_req) begin
      st_addr = in_ch.address[ADDR_WIDTH-1:0];
      st_left = in_ch.length;
      st_wr   = in_ch.op[0];
    end else if (phase_r == PH_POLL) begin
      st_addr = addr_r;
      st_left = left_r;
      st_wr   = wr_r;
    end else begin
      st_addr = addr_inc;
      st_left = left_dec;
      st_wr   = wr_r;
    end
    st_len = chunk_len(st_addr, st_left, cfg.page_log2);
  end

  // next chunk, done when nothing is left, or reject when no address bytes are set
  always_comb begin
    nd_kind  = sps_pkg::KIND_DONE;
    nd_tail  = sps_pkg::TL_ONE;
    nd_phase = PH_IDLE;
    nd_left  = 24'd0;
    nd_chunk = 9'd0;
    if (st_left == 24'd0) begin
      nd_kind = sps_pkg::KIND_DONE;
    end else if (cfg.addr_bytes == 2'd0) begin
      nd_kind = sps_pkg::KIND_REJECT;
    end else begin
      nd_tail  = sps_pkg::TL_CHUNK;
      nd_phase = st_wr ? PH_WDATA : PH_RDATA;
      nd_left  = st_left;
      nd_chunk = st_len;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    addr_nxt    = addr_r;
    left_nxt    = left_r;
    chunk_nxt   = chunk_r;
    elapsed_nxt = elapsed_r;
    wr_nxt      = wr_r;
    q_push      = 1'b0;
    q_plan      = '0;
    q_plan.addr       = 24'(st_addr);
    q_plan.addr_bytes = cfg.addr_bytes;
    q_plan.is_write   = st_wr;
    q_plan.status     = 8'(({7'd0, in_ch.wp_enable} << sps_pkg::SR_WPEN)
                           | ({7'd0, in_ch.block_protect1} << sps_pkg::SR_BP1)
                           | ({7'd0, in_ch.block_protect0} << sps_pkg::SR_BP0));
    if (accept) begin
      q_push            = 1'b1;
      q_plan.tail       = sps_pkg::TL_ONE;
      q_plan.one_kind   = sps_pkg::KIND_REJECT;
      unique case (in_ch.op)
        sps_pkg::OP_READ, sps_pkg::OP_WRITE: begin
          if (phase_r == PH_IDLE) begin
            wr_nxt          = in_ch.op[0];
            addr_nxt        = st_addr;
            q_plan.tail     = nd_tail;
            q_plan.one_kind = nd_kind;
            phase_nxt       = nd_phase;
            left_nxt        = nd_left;
            chunk_nxt       = nd_chunk;
          end
        end
        sps_pkg::OP_WDATA: begin
          if (phase_r == PH_WDATA) begin
            q_plan.head_en = 1'b1;
            q_plan.head    = '{kind: sps_pkg::KIND_SEND, value: in_ch.data};
            q_plan.tail    = sps_pkg::TL_NONE;
            addr_nxt       = addr_inc;
            left_nxt       = left_dec;
            chunk_nxt      = chunk_dec;
            if (chunk_dec == 9'd0) begin
              q_plan.rel_en = 1'b1;
              if (cfg.poll) begin
                elapsed_nxt = 16'd0;
                phase_nxt   = PH_POLL;
                q_plan.tail = sps_pkg::TL_POLL;
              end else begin
                q_plan.tail     = nd_tail;
                q_plan.one_kind = nd_kind;
                phase_nxt       = nd_phase;
                left_nxt        = nd_left;
                chunk_nxt       = nd_chunk;
              end
            end
          end
        end
        sps_pkg::OP_RXBYTE: begin
          if (phase_r == PH_RDATA) begin
            q_plan.head_en = 1'b1;
            q_plan.head    = '{kind: sps_pkg::KIND_RDBYTE, value: in_ch.data};
            addr_nxt       = addr_inc;
            left_nxt       = left_dec;
            chunk_nxt      = chunk_dec;
            if (chunk_dec == 9'd0) begin
              q_plan.rel_en   = 1'b1;
              q_plan.tail     = nd_tail;
              q_plan.one_kind = nd_kind;
              phase_nxt       = nd_phase;
              left_nxt        = nd_left;
              chunk_nxt       = nd_chunk;
            end else begin
              q_plan.one_kind = sps_pkg::KIND_CLKIN;
            end
          end else if (phase_r == PH_POLL) begin
            q_plan.head_en = 1'b1;
            q_plan.head    = '{kind: sps_pkg::KIND_RELEASE, value: 8'd0};
            if (!in_ch.data[0]) begin
              q_plan.tail     = nd_tail;
              q_plan.one_kind = nd_kind;
              phase_nxt       = nd_phase;
              left_nxt        = nd_left;
              chunk_nxt       = nd_chunk;
            end else if (cfg.timeout != 16'd0 && elapsed_r >= cfg.timeout) begin
              q_plan.one_kind = sps_pkg::KIND_TIMEOUT;
              phase_nxt       = PH_IDLE;
              left_nxt        = 24'd0;
              chunk_nxt       = 9'd0;
            end else begin
              q_plan.tail = sps_pkg::TL_POLL;
            end
          end
        end
        sps_pkg::OP_TICK: begin
          q_push = 1'b0;
          if (phase_r == PH_POLL && elapsed_r != 16'hFFFF) begin
            elapsed_nxt = elapsed_r + 16'd1;
          end
        end
        sps_pkg::OP_PROTECT: begin
          if (phase_r == PH_IDLE) begin
            wr_nxt      = 1'b0;
            q_plan.tail = sps_pkg::TL_PROT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      addr_r    <= '0;
      left_r    <= 24'd0;
      chunk_r   <= 9'd0;
      elapsed_r <= 16'd0;
      wr_r      <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      addr_r    <= addr_nxt;
      left_r    <= left_nxt;
      chunk_r   <= chunk_nxt;
      elapsed_r <= elapsed_nxt;
      wr_r      <= wr_nxt;
    end
  end

endmodule

/* sv/sps_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_queue
// Small first-in first-out queue of result plans.
// ----------------------------------------------------------------------------
module sps_queue #(
  parameter int DEPTH = sps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sps_pkg::plan_t  push_data,
  input  logic            pop,
  output sps_pkg::plan_t  pop_data,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sps_pkg::plan_t     mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

/* sv/sps_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_back
// Expand result plans into beats and drive the result channel.
// ----------------------------------------------------------------------------
module sps_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  sps_pkg::plan_t  q_plan,
  output logic            q_pop,
  sps_out_if.source       out_ch
);

  localparam int IDX_W = sps_pkg::IDX_W;

  sps_pkg::beat_t   seq_r [sps_pkg::MAX_RES];
  sps_pkg::beat_t   seq   [sps_pkg::MAX_RES];
  logic [IDX_W-1:0] cnt_r, cnt, idx_r;
  logic             busy_r;
  logic             ovld_r, olast_r;
  sps_pkg::beat_t   obeat_r;
  logic             advance;

  // lay out the beats of the plan at the head of the queue
  always_comb begin
    logic [IDX_W-1:0] p;
    p = '0;
    for (int k = 0; k < sps_pkg::MAX_RES; k++) begin
      seq[k] = '0;
    end
    if (q_plan.head_en) begin
      seq[p] = q_plan.head;
      p = p + IDX_W'(1);
    end
    if (q_plan.rel_en) begin
      seq[p] = '{kind: sps_pkg::KIND_RELEASE, value: 8'd0};
      p = p + IDX_W'(1);
    end
    unique case (q_plan.tail)
      sps_pkg::TL_ONE: begin
        seq[p] = '{kind: q_plan.one_kind, value: 8'd0};
        p = p + IDX_W'(1);
      end
      sps_pkg::TL_POLL: begin
        seq[p] = '{kind: sps_pkg::KIND_SELECT, value: 8'd0};
        seq[p + IDX_W'(1)] = '{kind: sps_pkg::KIND_SEND, value: sps_pkg::CMD_RDSR};
        seq[p + IDX_W'(2)] = '{kind: sps_pkg::KIND_CLKIN, value: 8'd0};
        p = p + IDX_W'(3);
      end
      sps_pkg::TL_CHUNK: begin
        if (q_plan.is_write) begin
          seq[p] = '{kind: sps_pkg::KIND_SELECT, value: 8'd0};
          seq[p + IDX_W'(1)] = '{kind: sps_pkg::KIND_SEND, value: sps_pkg::CMD_WREN};
          seq[p + IDX_W'(2)] = '{kind: sps_pkg::KIND_RELEASE, value: 8'd0};
          p = p + IDX_W'(3);
        end
        seq[p] = '{kind: sps_pkg::KIND_SELECT, value: 8'd0};
        seq[p + IDX_W'(1)] = '{kind: sps_pkg::KIND_SEND,
                               value: q_plan.is_write ? sps_pkg::CMD_WRITE
                                                      : sps_pkg::CMD_READ};
        p = p + IDX_W'(2);
        for (int i = 3; i >= 1; i--) begin
          if (2'(i) <= q_plan.addr_bytes) begin
            seq[p] = '{kind: sps_pkg::KIND_SEND, value: q_plan.addr[8*i-1 -: 8]};
            p = p + IDX_W'(1);
          end
        end
        if (!q_plan.is_write) begin
          seq[p] = '{kind: sps_pkg::KIND_CLKIN, value: 8'd0};
          p = p + IDX_W'(1);
        end
      end
      sps_pkg::TL_PROT: begin
        seq[p] = '{kind: sps_pkg::KIND_SELECT, value: 8'd0};
        seq[p + IDX_W'(1)] = '{kind: sps_pkg::KIND_SEND, value: sps_pkg::CMD_WREN};
        seq[p + IDX_W'(2)] = '{kind: sps_pkg::KIND_RELEASE, value: 8'd0};
        seq[p + IDX_W'(3)] = '{kind: sps_pkg::KIND_SELECT, value: 8'd0};
        seq[p + IDX_W'(4)] = '{kind: sps_pkg::KIND_SEND, value: sps_pkg::CMD_WRSR};
        seq[p + IDX_W'(5)] = '{kind: sps_pkg::KIND_SEND, value: q_plan.status};
        seq[p + IDX_W'(6)] = '{kind: sps_pkg::KIND_RELEASE, value: 8'd0};
        seq[p + IDX_W'(7)] = '{kind: sps_pkg::KIND_DONE, value: 8'd0};
        p = p + IDX_W'(8);
      end
      default: begin
      end
    endcase
    cnt = p;
  end

  assign q_pop   = !busy_r && !q_empty;
  assign advance = !ovld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      seq_r <= seq;
      cnt_r <= cnt;
    end
    if (advance && busy_r) begin
      obeat_r <= seq_r[idx_r];
      olast_r <= (idx_r == cnt_r - IDX_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (advance && busy_r) begin
        if (idx_r == cnt_r - IDX_W'(1)) begin
          busy_r <= 1'b0;
        end
        idx_r <= idx_r + IDX_W'(1);
      end
      if (advance) begin
        ovld_r <= busy_r;
      end
    end
  end

  assign out_ch.valid = ovld_r;
  assign out_ch.kind  = obeat_r.kind;
  assign out_ch.value = obeat_r.value;
  assign out_ch.last  = olast_r;

endmodule

/* sv/spi_eeprom_page_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_eeprom_page_sequencer
// Host-side 25xx SPI EEPROM sequencer: page-split reads, writes and polls.
// ----------------------------------------------------------------------------
// Each request item (read, write, protect) or bus byte (write data, received
// byte, tick) is taken by the front end, which updates the request state and
// queues a compact plan of the beats it causes; the back end then plays those
// beats out one per cycle while the result sink is ready, and takes the next
// plan only after it has moved the last beat of the current one into its output
// register. The front end keeps taking items while the plan queue has room;
// ticks produce no beats and are taken every cycle while the plan queue has
// room. Requests split at page boundaries (page size is 2**page_log2, capped
// at 256); each chunk is one select/command/address frame, writes preceded by
// a write-enable frame and, with polling on, followed by status polls.
// Configuration sits behind an APB port, one 32-bit register every four
// bytes; write it only while the block is idle.
// ----------------------------------------------------------------------------
module spi_eeprom_page_sequencer #(
  parameter int ADDR_WIDTH  = sps_pkg::ADDR_WIDTH_DEF,
  parameter int QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sps_in_if.sink      in_ch,
  sps_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sps_pkg::cfg_t  cfg_r;
  sps_pkg::plan_t push_plan, pop_plan;
  logic           push, pop, full, empty;
  logic           cfg_wr;
  logic [1:0]     reg_idx;

  // Configuration: write in the access phase, read back at any time.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.addr_bytes <= sps_pkg::RST_ADDR_BYTES;
      cfg_r.page_log2  <= sps_pkg::RST_PAGE_LOG2;
      cfg_r.poll       <= sps_pkg::RST_POLL;
      cfg_r.timeout    <= sps_pkg::RST_TIMEOUT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sps_pkg::REG_ADDR_BYTES: cfg_r.addr_bytes <= pwdata[1:0];
        sps_pkg::REG_PAGE_LOG2:  cfg_r.page_log2  <= pwdata[3:0];
        sps_pkg::REG_POLL:       cfg_r.poll       <= pwdata[0];
        sps_pkg::REG_TIMEOUT:    cfg_r.timeout    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sps_pkg::REG_ADDR_BYTES: prdata = {30'd0, cfg_r.addr_bytes};
      sps_pkg::REG_PAGE_LOG2:  prdata = {28'd0, cfg_r.page_log2};
      sps_pkg::REG_POLL:       prdata = {31'd0, cfg_r.poll};
      sps_pkg::REG_TIMEOUT:    prdata = {16'd0, cfg_r.timeout};
      default:                 prdata = 32'd0;
    endcase
  end

  // Front end: classify each beat and hold the request state.
  sps_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (full),
    .q_push (push),
    .q_plan (push_plan)
  );

  // Plan queue: decouple acceptance from beat delivery.
  sps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_plan),
    .pop       (pop),
    .pop_data  (pop_plan),
    .full      (full),
    .empty     (empty)
  );

  // Back end: expand each plan and drive the result channel.
  sps_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (empty),
    .q_plan  (pop_plan),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

/* sv/sps_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks on the result channel of the page sequencer.
// ----------------------------------------------------------------------------
`include "spi_eeprom_page_sequencer_assert.svh"

module sps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [7:0] value,
  input logic       last
);

  `SPS_ASSERT_NEXT(a_valid_held, out_valid && !out_ready, out_valid, "result beat dropped")
  `SPS_ASSERT_NOW(a_end_last, out_valid && (kind == sps_pkg::KIND_DONE || kind == sps_pkg::KIND_TIMEOUT || kind == sps_pkg::KIND_REJECT), last, "ending beat not last")
  `SPS_ASSERT_NOW(a_clkin_last, out_valid && kind == sps_pkg::KIND_CLKIN, last, "clock-in beat not last")
  `SPS_ASSERT_NOW(a_value_zero, out_valid && kind != sps_pkg::KIND_SEND && kind != sps_pkg::KIND_RDBYTE, value == 8'd0, "value not zero")

endmodule

bind spi_eeprom_page_sequencer sps_checker u_sps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .kind      (out_ch.kind),
  .value     (out_ch.value),
  .last      (out_ch.last)
);

/* bench/spi_eeprom_page_sequencer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_eeprom_page_sequencer_tb
// Self-checking bench for the SPI EEPROM page sequencer. Requests, bus bytes
// and ticks go in over the item channel, APB writes change the registers
// between phases, and every result beat is checked against a predictor of
// the request state held in a small scoreboard class.
// ----------------------------------------------------------------------------
module spi_eeprom_page_sequencer_tb;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RDATA = 2'd1;
  localparam logic [1:0] PH_WDATA = 2'd2;
  localparam logic [1:0] PH_POLL  = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM    = 240;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
  } res_beat_t;

  // Predictor of the sequencer plus the queue of beats it owes.
  class beat_board;
    logic [1:0]  addr_bytes;
    logic [3:0]  page_log2;
    logic        poll;
    logic [15:0] timeout;
    logic [1:0]  phase;
    logic [23:0] cur_addr;
    logic [23:0] left;
    logic [23:0] chunk;
    logic [15:0] elapsed;
    logic        wr;
    res_beat_t   owed[$];
    res_beat_t   fresh[$];
    int          errors;

    function void reset_state();
      addr_bytes = sps_pkg::RST_ADDR_BYTES; page_log2 = sps_pkg::RST_PAGE_LOG2;
      poll = sps_pkg::RST_POLL; timeout = sps_pkg::RST_TIMEOUT;
      phase = PH_IDLE; cur_addr = 0; left = 0; chunk = 0; elapsed = 0; wr = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        sps_pkg::REG_ADDR_BYTES: addr_bytes = v[1:0];
        sps_pkg::REG_PAGE_LOG2:  page_log2 = v[3:0];
        sps_pkg::REG_POLL:       poll = v[0];
        default:                 timeout = v[15:0];
      endcase
    endfunction

    function void push(logic [2:0] k, logic [7:0] v);
      res_beat_t b;
      b.kind = k; b.value = v; b.last = 1'b0;
      fresh.push_back(b);
    endfunction

    function void go_idle();
      phase = PH_IDLE; left = 0; chunk = 0;
    endfunction

    function void open_chunk();
      logic [3:0]  lg;
      logic [24:0] page, room;
      lg = (page_log2 > 8) ? 4'd8 : page_log2;
      page = 25'd1 << lg;
      room = page - (cur_addr & (page - 1));
      if (addr_bytes == 0) begin
        push(sps_pkg::KIND_REJECT, 0); go_idle(); return;
      end
      chunk = (left < room) ? left : room[23:0];
      if (wr) begin
        push(sps_pkg::KIND_SELECT, 0); push(sps_pkg::KIND_SEND, sps_pkg::CMD_WREN);
        push(sps_pkg::KIND_RELEASE, 0);
      end
      push(sps_pkg::KIND_SELECT, 0);
      push(sps_pkg::KIND_SEND, wr ? sps_pkg::CMD_WRITE : sps_pkg::CMD_READ);
      for (int i = addr_bytes; i > 0; i--)
        push(sps_pkg::KIND_SEND, 8'(cur_addr >> (8 * (i - 1))));
      if (wr) phase = PH_WDATA;
      else begin
        push(sps_pkg::KIND_CLKIN, 0); phase = PH_RDATA;
      end
    endfunction

    function void next_or_done();
      if (left == 0) begin
        push(sps_pkg::KIND_DONE, 0); go_idle();
      end else open_chunk();
    endfunction

    function void step_on();
      cur_addr++;
      if (left > 0) left--;
      if (chunk > 0) chunk--;
    endfunction

    function void status_poll();
      push(sps_pkg::KIND_SELECT, 0); push(sps_pkg::KIND_SEND, sps_pkg::CMD_RDSR);
      push(sps_pkg::KIND_CLKIN, 0);
    endfunction

    // Note one accepted item and queue the beats it causes.
    function void note_item(logic [2:0] op, logic [23:0] a, logic [23:0] n,
                            logic [7:0] d, logic wp, logic b0, logic b1);
      fresh.delete();
      case (op)
        sps_pkg::OP_READ, sps_pkg::OP_WRITE: begin
          if (phase != PH_IDLE) push(sps_pkg::KIND_REJECT, 0);
          else if (n == 0) push(sps_pkg::KIND_DONE, 0);
          else begin
            wr = op[0]; cur_addr = a; left = n; open_chunk();
          end
        end
        sps_pkg::OP_WDATA: begin
          if (phase != PH_WDATA) push(sps_pkg::KIND_REJECT, 0);
          else begin
            push(sps_pkg::KIND_SEND, d); step_on();
            if (chunk == 0) begin
              push(sps_pkg::KIND_RELEASE, 0);
              if (poll) begin
                elapsed = 0; phase = PH_POLL; status_poll();
              end else next_or_done();
            end
          end
        end
        sps_pkg::OP_RXBYTE: begin
          if (phase == PH_RDATA) begin
            push(sps_pkg::KIND_RDBYTE, d); step_on();
            if (chunk == 0) begin
              push(sps_pkg::KIND_RELEASE, 0); next_or_done();
            end else push(sps_pkg::KIND_CLKIN, 0);
          end else if (phase == PH_POLL) begin
            push(sps_pkg::KIND_RELEASE, 0);
            if (!d[0]) next_or_done();
            else if (timeout != 0 && elapsed >= timeout) begin
              push(sps_pkg::KIND_TIMEOUT, 0); go_idle();
            end else status_poll();
          end else push(sps_pkg::KIND_REJECT, 0);
        end
        sps_pkg::OP_TICK: if (phase == PH_POLL && elapsed != 16'hFFFF) elapsed++;
        sps_pkg::OP_PROTECT: begin
          if (phase != PH_IDLE) push(sps_pkg::KIND_REJECT, 0);
          else begin
            wr = 0;
            push(sps_pkg::KIND_SELECT, 0); push(sps_pkg::KIND_SEND, sps_pkg::CMD_WREN);
            push(sps_pkg::KIND_RELEASE, 0);
            push(sps_pkg::KIND_SELECT, 0); push(sps_pkg::KIND_SEND, sps_pkg::CMD_WRSR);
            push(sps_pkg::KIND_SEND, ({7'd0, wp} << sps_pkg::SR_WPEN)
                                   | ({7'd0, b0} << sps_pkg::SR_BP0)
                                   | ({7'd0, b1} << sps_pkg::SR_BP1));
            push(sps_pkg::KIND_RELEASE, 0); push(sps_pkg::KIND_DONE, 0);
          end
        end
        default: push(sps_pkg::KIND_REJECT, 0);
      endcase
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) owed.push_back(fresh[i]);
    endfunction

    function void check_beat(res_beat_t got);
      res_beat_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected beat kind=%0d value=%0h last=%0b",
                 $time, got.kind, got.value, got.last);
        errors++; return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        $display("%0t: beat mismatch expected kind=%0d value=%0h last=%0b, %s",
                 $time, want.kind, want.value, want.last, "actual");
        $display("%0t:   actual kind=%0d value=%0h last=%0b",
                 $time, got.kind, got.value, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int   cycles = 0;
  int   n_items = 0;
  bit   calm = 1'b0;      // no idling on either side while set
  beat_board board;

  sps_in_if  in_ch ();
  sps_out_if out_ch ();

  spi_eeprom_page_sequencer dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.op = '0; in_ch.address = '0; in_ch.length = '0;
    in_ch.data = '0; in_ch.wp_enable = 0; in_ch.block_protect0 = 0;
    in_ch.block_protect1 = 0;
    out_ch.ready = 1'b0;
  end

  // Count cycles; give up at the limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sample result beats at the rising edge and check them.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_beat({out_ch.kind, out_ch.value, out_ch.last});
  end

  // Stall the result side at random, changing on the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 18);
  end

  // Drop valid at the next falling edge.
  task automatic release_in();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Write one register over APB: setup, then access.
  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_reg(idx, v);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Hold until every owed beat is out, then let the back end settle.
  task automatic drain();
    release_in();
    while (board.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Drive one item at a falling edge, after random gaps unless calm is set; hold it until it is taken.
  task automatic send_item(logic [2:0] op, logic [23:0] a = 0, logic [23:0] n = 0,
                           logic [7:0] d = 0, logic [2:0] prot = 0);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.op <= op; in_ch.address <= a; in_ch.length <= n;
    in_ch.data <= d; in_ch.wp_enable <= prot[0]; in_ch.block_protect0 <= prot[1];
    in_ch.block_protect1 <= prot[2];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_item(op, a, n, d, prot[0], prot[1], prot[2]);
    n_items++;
  endtask

  // Feed whatever the current phase waits for, with some noise mixed in.
  task automatic feed_request();
    int guard;
    guard = 0;
    while (board.phase != PH_IDLE && guard < 40) begin
      guard++;
      if ($urandom_range(0, 19) == 0)
        send_item(3'($urandom_range(0, 7)), $urandom, $urandom_range(0, 3), $urandom);
      else case (board.phase)
        PH_WDATA: send_item(sps_pkg::OP_WDATA, 0, 0, $urandom);
        PH_RDATA: send_item(sps_pkg::OP_RXBYTE, 0, 0, $urandom);
        default: begin
          if ($urandom_range(0, 2) == 0) send_item(sps_pkg::OP_TICK);
          else send_item(sps_pkg::OP_RXBYTE, 0, 0,
                         {7'($urandom), 1'($urandom_range(0, 3) == 0)});
        end
      endcase
    end
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) send_item(sps_pkg::OP_WRITE, $urandom, $urandom_range(1, 6));
    else if (pick < 8) send_item(sps_pkg::OP_READ, $urandom, $urandom_range(0, 6));
    else if (pick == 8) send_item(sps_pkg::OP_PROTECT, 0, 0, 0, 3'($urandom));
    else send_item(3'($urandom_range(2, 7)), $urandom, $urandom, $urandom);
    feed_request();
  endtask

  initial begin
    int base;
    board = new();
    board.reset_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings first.
    send_item(sps_pkg::OP_READ, 24'h000010, 0);          // zero length
    send_item(sps_pkg::OP_WDATA, 0, 0, 8'hA5);           // stray write byte
    send_item(sps_pkg::OP_RXBYTE, 0, 0, 8'h5A);          // stray received byte
    send_item(3'd6); send_item(3'd7);                    // unknown ops
    send_item(sps_pkg::OP_TICK);
    send_item(sps_pkg::OP_PROTECT, 0, 0, 0, 3'b111);
    send_item(sps_pkg::OP_PROTECT, 0, 0, 0, 3'b000);
    send_item(sps_pkg::OP_READ, 24'hFFFFFF, 2);          // address wrap
    send_item(sps_pkg::OP_WRITE, 0, 0);                  // busy request
    send_item(sps_pkg::OP_RXBYTE, 0, 0, 8'hFF);
    send_item(sps_pkg::OP_RXBYTE, 0, 0, 8'h00);
    send_item(sps_pkg::OP_WRITE, 24'h00003F, 2);         // crosses a page
    send_item(sps_pkg::OP_WDATA, 0, 0, 8'hFF);
    send_item(sps_pkg::OP_RXBYTE, 0, 0, 8'h01);
    send_item(sps_pkg::OP_RXBYTE, 0, 0, 8'h00);
    send_item(sps_pkg::OP_WDATA, 0, 0, 8'h00);
    send_item(sps_pkg::OP_RXBYTE, 0, 0, 8'h00);
    drain();

    // Directed: poll timeout with a short limit.
    reg_write(sps_pkg::REG_TIMEOUT, 2);
    send_item(sps_pkg::OP_WRITE, 24'h123456, 1);
    send_item(sps_pkg::OP_WDATA, 0, 0, 8'h3C);
    send_item(sps_pkg::OP_TICK); send_item(sps_pkg::OP_TICK);
    send_item(sps_pkg::OP_RXBYTE, 0, 0, 8'h01);
    drain();

    // Directed: zero address bytes rejects the request.
    reg_write(sps_pkg::REG_ADDR_BYTES, 0);
    send_item(sps_pkg::OP_READ, 24'h000001, 1);
    drain();

    // Random phases over a spread of settings, extremes included.
    base = n_items;
    for (int p = 0; p < 8; p++) begin
      drain();
      reg_write(sps_pkg::REG_ADDR_BYTES, (p == 7) ? 0 : (p % 3) + 1);
      reg_write(sps_pkg::REG_PAGE_LOG2,
                (p == 0) ? 0 : (p == 1) ? 8 : (p == 2) ? 15 : $urandom_range(0, 4));
      reg_write(sps_pkg::REG_POLL, p[0]);
      reg_write(sps_pkg::REG_TIMEOUT,
                (p == 3) ? 0 : (p == 4) ? 16'hFFFF : $urandom_range(1, 4));
      calm = (p == 5);
      if (p == 6) begin
        // Hold off until all owed beats are out before the next request.
        random_request();
        release_in();
        while (board.owed.size() != 0) @(posedge clk);
      end
      while (n_items - base < (p + 1) * (N_RANDOM / 8)) begin
        random_request();
      end
    end
    calm = 1'b0;

    drain();
    repeat (30) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* spi_eeprom_page_sequencer.f */
+incdir+sv
sv/sps_pkg.sv
sv/sps_if.sv
sv/sps_front.sv
sv/sps_queue.sv
sv/sps_back.sv
sv/spi_eeprom_page_sequencer.sv
sv/sps_checker.sv
bench/spi_eeprom_page_sequencer_tb.sv
